FILE: design/spic_pkg.sv
// Shared types, constants and register codes for the speed PID block.
package spic_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int INTEGRAL_WIDTH_DEF = 24;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int GAIN_WIDTH      = 16;
    localparam int LIMIT_WIDTH     = 15;
    localparam int CAP_WIDTH       = 24;
    localparam int DRIVE_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic signed [GAIN_WIDTH-1:0] KP_RESET    = -16'sd12800;
    localparam logic signed [GAIN_WIDTH-1:0] KI_RESET    = -16'sd1536;
    localparam logic signed [GAIN_WIDTH-1:0] KD_RESET    = 16'sd0;
    localparam logic [LIMIT_WIDTH-1:0]       LIMIT_RESET = 15'd7000;
    localparam logic signed [CAP_WIDTH-1:0]  CAP_RESET   = -24'sd1166;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_KP_GAIN      = 3'd0,
        REG_KI_GAIN      = 3'd1,
        REG_KD_GAIN      = 3'd2,
        REG_OUTPUT_LIMIT = 3'd3,
        REG_INTEGRAL_CAP = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]  kp_gain;
        logic [GAIN_WIDTH-1:0]  ki_gain;
        logic [GAIN_WIDTH-1:0]  kd_gain;
        logic [LIMIT_WIDTH-1:0] output_limit;
        logic [CAP_WIDTH-1:0]   integral_cap;
    } t_cfg;

endpackage

FILE: design/spic_regs.sv
// Configuration register file for the speed PID block.
module spic_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [spic_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [spic_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output spic_pkg::t_cfg                        o_cfg
);
    import spic_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain      <= KP_RESET;
            r_cfg.ki_gain      <= KI_RESET;
            r_cfg.kd_gain      <= KD_RESET;
            r_cfg.output_limit <= LIMIT_RESET;
            r_cfg.integral_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KP_GAIN:      r_cfg.kp_gain      <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_KI_GAIN:      r_cfg.ki_gain      <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_KD_GAIN:      r_cfg.kd_gain      <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_OUTPUT_LIMIT: r_cfg.output_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                REG_INTEGRAL_CAP: r_cfg.integral_cap <= i_cfg_data[CAP_WIDTH-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/spic_core.sv
// PID arithmetic, integral/previous-error state, one sample per i_advance cycle.
module spic_core #(
    parameter int SAMPLE_WIDTH   = spic_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = spic_pkg::INTEGRAL_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = spic_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_measured_speed,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_target_speed,
    input  spic_pkg::t_cfg                          i_cfg,
    output logic signed [spic_pkg::DRIVE_WIDTH-1:0] o_drive_value,
    output logic                                    o_integral_clamped
);
    import spic_pkg::*;

    localparam int EW   = SAMPLE_WIDTH + 1;                 // error
    localparam int DW   = SAMPLE_WIDTH + 2;                 // error difference
    localparam int IW   = INTEGRAL_WIDTH;
    localparam int SUMW = ((IW > EW) ? IW : EW) + 1;        // unsaturated sum
    localparam int CW   = (IW > CAP_WIDTH) ? IW : CAP_WIDTH;
    localparam int MW   = (IW > DW) ? IW : DW;
    localparam int TW   = GAIN_WIDTH + MW + 2;              // total of three terms
    localparam int PKP  = GAIN_WIDTH + EW;
    localparam int PKI  = GAIN_WIDTH + IW;
    localparam int PKD  = GAIN_WIDTH + DW;
    localparam logic [TW-1:0] BIAS = (TW'(1) << GAIN_FRAC_BITS) - TW'(1);
    localparam logic signed [IW-1:0] SUM_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] SUM_MIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

    logic signed [IW-1:0] r_integral_sum;
    logic signed [EW-1:0] r_prev_error;
    logic signed [IW-1:0] n_integral_sum;

    logic signed [GAIN_WIDTH-1:0] w_kp;
    logic signed [GAIN_WIDTH-1:0] w_ki;
    logic signed [GAIN_WIDTH-1:0] w_kd;
    logic signed [CW-1:0]         w_cap_ext;
    logic signed [IW-1:0]         w_cap_sat;
    logic signed [EW-1:0]         w_error;
    logic signed [DW-1:0]         w_diff;
    logic signed [SUMW-1:0]       w_sum_wide;
    logic signed [IW-1:0]         w_sum;
    logic signed [PKP-1:0]        w_p_kp;
    logic signed [PKI-1:0]        w_p_ki;
    logic signed [PKD-1:0]        w_p_kd;
    logic signed [TW-1:0]         w_total;
    logic signed [TW-1:0]         w_limit_scaled;
    logic signed [TW-1:0]         w_biased;
    logic signed [TW-1:0]         w_quot;
    logic                         w_clamp;

    assign w_kp = $signed(i_cfg.kp_gain);
    assign w_ki = $signed(i_cfg.ki_gain);
    assign w_kd = $signed(i_cfg.kd_gain);

    assign w_error = EW'(i_measured_speed) - EW'(i_target_speed);
    assign w_diff  = DW'(w_error) - DW'(r_prev_error);

    // saturating accumulate
    assign w_sum_wide = SUMW'(r_integral_sum) + SUMW'(w_error);
    always_comb begin
        if ((&w_sum_wide[SUMW-1:IW-1]) || !(|w_sum_wide[SUMW-1:IW-1])) begin
            w_sum = w_sum_wide[IW-1:0];
        end else begin
            w_sum = w_sum_wide[SUMW-1] ? SUM_MIN : SUM_MAX;
        end
    end

    // cap fitted to the sum's range
    assign w_cap_ext = CW'($signed(i_cfg.integral_cap));
    always_comb begin
        if ((&w_cap_ext[CW-1:IW-1]) || !(|w_cap_ext[CW-1:IW-1])) begin
            w_cap_sat = w_cap_ext[IW-1:0];
        end else begin
            w_cap_sat = w_cap_ext[CW-1] ? SUM_MIN : SUM_MAX;
        end
    end

    assign w_p_kp = PKP'(w_kp) * PKP'(w_error);
    assign w_p_ki = PKI'(w_ki) * PKI'(w_sum);
    assign w_p_kd = PKD'(w_kd) * PKD'(w_diff);

    assign w_total = TW'(w_p_kp) + TW'(w_p_ki) + TW'(w_p_kd);

    assign w_limit_scaled = TW'($signed({1'b0, i_cfg.output_limit})) <<< GAIN_FRAC_BITS;
    assign w_clamp        = TW'(w_p_ki) > w_limit_scaled;

    // truncate toward zero: bias negative totals before the arithmetic shift
    assign w_biased = w_total + (w_total[TW-1] ? $signed(BIAS) : $signed(TW'(0)));
    assign w_quot   = w_biased >>> GAIN_FRAC_BITS;

    always_comb begin
        if ((&w_quot[TW-1:DRIVE_WIDTH-1]) || !(|w_quot[TW-1:DRIVE_WIDTH-1])) begin
            o_drive_value = w_quot[DRIVE_WIDTH-1:0];
        end else begin
            o_drive_value = w_quot[TW-1] ? DRIVE_MIN : DRIVE_MAX;
        end
    end

    assign o_integral_clamped = w_clamp;
    assign n_integral_sum     = w_clamp ? w_cap_sat : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral_sum <= '0;
            r_prev_error   <= '0;
        end else if (i_advance) begin
            r_integral_sum <= n_integral_sum;
            r_prev_error   <= w_error;
        end
    end

endmodule

FILE: design/speed_pid_integral_clamp.sv
// Speed PID with one-sided integral clamp: input register, PID core, result register.
// An accepted sample goes to the input register, then its result to the result register.
// Throughput: one sample per cycle unless i_out_stall holds a full result register; the
// integral loop (saturating add, ki multiply, limit compare) is combinational.
// Reset (synchronous, active low): empties both stages, zeroes the integral sum and
// previous error, and loads the gain, limit and cap registers with their defaults.
module speed_pid_integral_clamp #(
    parameter int SAMPLE_WIDTH   = spic_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = spic_pkg::INTEGRAL_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = spic_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [spic_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [spic_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_measured_speed,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_target_speed,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [spic_pkg::DRIVE_WIDTH-1:0] o_drive_value,
    output logic                                    o_integral_clamped
);
    import spic_pkg::*;

    t_cfg w_cfg;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_measured;
    logic signed [SAMPLE_WIDTH-1:0] r_target;
    logic                           r_out_valid;
    logic signed [DRIVE_WIDTH-1:0]  r_drive;
    logic                           r_clamped;

    logic                           w_out_free;
    logic                           w_advance;
    logic                           w_in_take;
    logic signed [DRIVE_WIDTH-1:0]  w_drive;
    logic                           w_clamped;

    spic_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    spic_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_advance),
        .i_measured_speed   (r_measured),
        .i_target_speed     (r_target),
        .i_cfg              (w_cfg),
        .o_drive_value      (w_drive),
        .o_integral_clamped (w_clamped)
    );

    // advance the sample into the result register when that register is free
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign w_in_take  = !r_in_valid || w_advance;
    assign o_in_stall = !w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_measured <= i_measured_speed;
            r_target   <= i_target_speed;
        end
        if (w_advance) begin
            r_drive   <= w_drive;
            r_clamped <= w_clamped;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_value      = r_drive;
    assign o_integral_clamped = r_clamped;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("advanced transaction did not reach the result register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
